// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the texel codec rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ttc_pkg.sv =====
// ---------------------------------------------------------------------------
// ttc_pkg
// types and codes shared by the texel codec modules
// ---------------------------------------------------------------------------
package ttc_pkg;

    localparam int ADDR_W  = 21;
    localparam int COORD_W = 10;
    localparam int SIDE_W  = 11;

    // color modes
    localparam logic [1:0] COLOR_A1R5G5B5 = 2'd0;
    localparam logic [1:0] COLOR_R5G6B5   = 2'd1;
    localparam logic [1:0] COLOR_A4R4G4B4 = 2'd2;
    localparam logic [1:0] COLOR_X1R5G5B5 = 2'd3;

    // opcodes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_SIZE = 2'd1;
    localparam logic [1:0] STAT_NO_ENC   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_COLOR_MODE = 2'd0;
    localparam logic [1:0] CFG_TWIDDLED   = 2'd1;
    localparam logic [1:0] CFG_WIDTH      = 2'd2;
    localparam logic [1:0] CFG_HEIGHT     = 2'd3;

    typedef struct packed {
        logic [1:0]        color_mode;
        logic              twiddled;
        logic [SIDE_W-1:0] width;
        logic [SIDE_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              size_bad;
    } addr_res_t;

endpackage

// ===== rtl/core/ttc_addr_gen.sv =====
// ---------------------------------------------------------------------------
// ttc_addr_gen
// texel byte address in raster or twiddled order, plus size check
// ---------------------------------------------------------------------------
module ttc_addr_gen
    import ttc_pkg::*;
#(
    parameter int MAX_SIDE = 1024
)
(
    input  cfg_t               cfg,
    input  logic [COORD_W-1:0] x_pos,
    input  logic [COORD_W-1:0] y_pos,
    output addr_res_t          res
);

    function automatic logic [2*COORD_W-1:0] spread(input logic [COORD_W-1:0] v);
        logic [2*COORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < COORD_W; i++)
        begin
            r[2*i] = v[i];
        end
        return r;
    endfunction

    logic                 w_lt_h;
    logic                 h_lt_w;
    logic [SIDE_W-1:0]    short_side;
    logic [SIDE_W-1:0]    long_side;
    logic [SIDE_W-1:0]    side_mask;
    logic                 size_ok;
    logic [3:0]           side_log;
    logic [COORD_W-1:0]   split_coord;
    logic [COORD_W-1:0]   low_coord;
    logic [COORD_W-1:0]   block_idx;
    logic [COORD_W-1:0]   odd_src;
    logic [COORD_W-1:0]   even_src;
    logic [2*COORD_W:0]   morton;
    logic [ADDR_W-1:0]    block_off;
    logic [ADDR_W-1:0]    twid_addr;
    logic [2*SIDE_W-1:0]  row_prod;
    logic [2*SIDE_W-1:0]  raster_sum;
    logic [ADDR_W-1:0]    raster_addr;

    always_comb
    begin
        w_lt_h     = cfg.width < cfg.height;
        h_lt_w     = cfg.height < cfg.width;
        short_side = w_lt_h ? cfg.width : cfg.height;
        long_side  = w_lt_h ? cfg.height : cfg.width;
        side_mask  = short_side - SIDE_W'(1);
        size_ok    = (short_side >= SIDE_W'(8))
                  && (32'(short_side) <= 32'(MAX_SIDE))
                  && ((short_side & side_mask) == '0)
                  && ((long_side & side_mask) == '0);

        // short side is one-hot when valid
        side_log = '0;
        for (int i = 0; i < SIDE_W; i++)
        begin
            if (short_side[i])
            begin
                side_log = 4'(i);
            end
        end

        // squares are laid along the longer side
        split_coord = h_lt_w ? x_pos : y_pos;
        block_idx   = split_coord >> side_log;
        low_coord   = split_coord & side_mask[COORD_W-1:0];
        odd_src     = h_lt_w ? low_coord : x_pos;
        even_src    = h_lt_w ? y_pos : low_coord;
        morton      = {spread(odd_src), 1'b0} | {1'b0, spread(even_src)};
        block_off   = ADDR_W'(block_idx) << ({side_log, 1'b0} + 5'd1);
        twid_addr   = block_off + {morton[ADDR_W-2:0], 1'b0};

        row_prod    = (2*SIDE_W)'(y_pos) * (2*SIDE_W)'(cfg.width);
        raster_sum  = row_prod + (2*SIDE_W)'(x_pos);
        raster_addr = {raster_sum[ADDR_W-2:0], 1'b0};

        if (!cfg.twiddled)
        begin
            res.addr     = raster_addr;
            res.size_bad = 1'b0;
        end
        else if (!size_ok)
        begin
            res.addr     = '0;
            res.size_bad = 1'b1;
        end
        else
        begin
            res.addr     = twid_addr;
            res.size_bad = 1'b0;
        end
    end

endmodule

// ===== rtl/core/texture_texel_codec.sv =====
// ---------------------------------------------------------------------------
// texture_texel_codec
// 16-bit texel encode/decode with raster or twiddled byte addressing
// ---------------------------------------------------------------------------
// channel   handshake              payload
// input     start / busy           opcode, x_pos, y_pos, rgba_in, texel_in
// result    done (one-cycle pulse) byte_address, texel_out, rgba_out, status
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one transaction per cycle; busy is always low
// each transaction passes the input register, then address and color logic into
// the result register; the raster multiply sets the critical path
// rst_n clears the valid pipeline and loads register defaults
// results cannot be held off, done is high for exactly one cycle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module texture_texel_codec
    import ttc_pkg::*;
#(
    parameter int MAX_SIDE = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [COORD_W-1:0] x_pos,
    input  logic [COORD_W-1:0] y_pos,
    input  logic [7:0]         red_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         blue_in,
    input  logic [7:0]         alpha_in,
    input  logic [15:0]        texel_in,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [SIDE_W-1:0]  cfg_data,
    output logic               done,
    output logic [ADDR_W-1:0]  byte_address,
    output logic [15:0]        texel_out,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out,
    output logic [7:0]         alpha_out,
    output logic [1:0]         status
);

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic               opcode_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic [7:0]         alpha_reg;
    logic [15:0]        texel_reg;

    logic               done_reg;
    logic [ADDR_W-1:0]  addr_out_reg;
    logic [15:0]        texel_out_reg;
    logic [7:0]         red_out_reg;
    logic [7:0]         green_out_reg;
    logic [7:0]         blue_out_reg;
    logic [7:0]         alpha_out_reg;
    logic [1:0]         status_reg;

    addr_res_t          addr_res;
    logic [15:0]        texel_next;
    logic [7:0]         red_next;
    logic [7:0]         green_next;
    logic [7:0]         blue_next;
    logic [7:0]         alpha_next;
    logic [1:0]         status_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_mode <= COLOR_R5G6B5;
            cfg_reg.twiddled   <= 1'b0;
            cfg_reg.width      <= SIDE_W'(8);
            cfg_reg.height     <= SIDE_W'(8);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COLOR_MODE: cfg_reg.color_mode <= cfg_data[1:0];
                CFG_TWIDDLED:   cfg_reg.twiddled   <= cfg_data[0];
                CFG_WIDTH:      cfg_reg.width      <= cfg_data;
                CFG_HEIGHT:     cfg_reg.height     <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            opcode_reg <= opcode;
            x_reg      <= x_pos;
            y_reg      <= y_pos;
            red_reg    <= red_in;
            green_reg  <= green_in;
            blue_reg   <= blue_in;
            alpha_reg  <= alpha_in;
            texel_reg  <= texel_in;
        end
    end

    ttc_addr_gen #(
        .MAX_SIDE (MAX_SIDE)
    ) u_addr_gen (
        .cfg   (cfg_reg),
        .x_pos (x_reg),
        .y_pos (y_reg),
        .res   (addr_res)
    );

    always_comb
    begin
        texel_next  = '0;
        red_next    = '0;
        green_next  = '0;
        blue_next   = '0;
        alpha_next  = '0;
        status_next = addr_res.size_bad ? STAT_BAD_SIZE : STAT_OK;

        if (opcode_reg == OP_ENCODE)
        begin
            case (cfg_reg.color_mode)
                COLOR_A1R5G5B5: texel_next = {alpha_reg[7], red_reg[7:3],
                                              green_reg[7:3], blue_reg[7:3]};
                COLOR_R5G6B5:   texel_next = {red_reg[7:3], green_reg[7:2],
                                              blue_reg[7:3]};
                COLOR_A4R4G4B4: texel_next = {alpha_reg[7:4], red_reg[7:4],
                                              green_reg[7:4], blue_reg[7:4]};
                default:
                begin
                    if (status_next == STAT_OK)
                    begin
                        status_next = STAT_NO_ENC;
                    end
                end
            endcase
        end
        else
        begin
            case (cfg_reg.color_mode)
                COLOR_R5G6B5:
                begin
                    red_next   = {texel_reg[15:11], texel_reg[15:13]};
                    green_next = {texel_reg[10:5], texel_reg[10:9]};
                    blue_next  = {texel_reg[4:0], texel_reg[4:2]};
                    alpha_next = 8'hff;
                end
                COLOR_A4R4G4B4:
                begin
                    red_next   = {texel_reg[11:8], texel_reg[11:8]};
                    green_next = {texel_reg[7:4], texel_reg[7:4]};
                    blue_next  = {texel_reg[3:0], texel_reg[3:0]};
                    alpha_next = {texel_reg[15:12], texel_reg[15:12]};
                end
                default:
                begin
                    red_next   = {texel_reg[14:10], texel_reg[14:12]};
                    green_next = {texel_reg[9:5], texel_reg[9:7]};
                    blue_next  = {texel_reg[4:0], texel_reg[4:2]};
                    alpha_next = (cfg_reg.color_mode == COLOR_A1R5G5B5)
                               ? {8{texel_reg[15]}} : 8'hff;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            addr_out_reg  <= addr_res.addr;
            texel_out_reg <= texel_next;
            red_out_reg   <= red_next;
            green_out_reg <= green_next;
            blue_out_reg  <= blue_next;
            alpha_out_reg <= alpha_next;
            status_reg    <= status_next;
        end
    end

    assign done         = done_reg;
    assign byte_address = addr_out_reg;
    assign texel_out    = texel_out_reg;
    assign red_out      = red_out_reg;
    assign green_out    = green_out_reg;
    assign blue_out     = blue_out_reg;
    assign alpha_out    = alpha_out_reg;
    assign status       = status_reg;

    `ASSERT_NEXT(a_accept_to_stage, clk, rst_n, start && !busy, in_valid_reg,
        "accepted transaction did not reach the input register")
    `ASSERT_NEXT(a_stage_to_done, clk, rst_n, in_valid_reg, done,
        "input register did not produce a result")
    `ASSERT_IMPLY(a_bad_size_addr, clk, rst_n, done && (status == STAT_BAD_SIZE),
        byte_address == '0, "bad twiddled size with nonzero address")
    `ASSERT_IMPLY(a_encode_no_rgba, clk, rst_n, done && (texel_out != '0),
        (red_out == '0) && (green_out == '0) && (blue_out == '0) && (alpha_out == '0),
        "encode result carries decoded channels")

endmodule
